// ----- design/lfu_pkg.sv -----
package lfu_pkg;

  localparam int ENTRIES    = 16;
  localparam int COUNT_BITS = 16;
  localparam int KEY_W      = 32;
  localparam int DATA_W     = 32;
  localparam int CAP_W      = 5;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int LVL_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  localparam logic [CAP_W-1:0]      CAP_RESET = CAP_W'(16);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SWEEP
  } state_t;

  typedef enum logic [1:0] {
    CELL_IDLE,
    CELL_BUMP,
    CELL_FILL,
    CELL_INSERT
  } cell_op_t;

  typedef struct packed {
    cell_op_t             op;
    logic                 wr_data;
    logic [IDX_W-1:0]     rank;
    logic [KEY_W-1:0]     key;
    logic [DATA_W-1:0]    data;
  } cell_cmd_t;

  typedef struct packed {
    logic                  vld;
    logic [COUNT_BITS-1:0] cnt;
    logic [IDX_W-1:0]      rank;
    logic [IDX_W-1:0]      idx;
  } cand_t;

  typedef struct packed {
    logic              vld;
    logic              hit;
    logic [IDX_W-1:0]  rank;
    logic [DATA_W-1:0] data;
  } cell_stat_t;

endpackage

// ----- design/lfu_if.sv -----
interface lfu_req_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [lfu_pkg::KEY_W-1:0]  key;
  logic [lfu_pkg::DATA_W-1:0] data_in;

  modport source (output valid, kind, key, data_in, input ready);
  modport sink   (input valid, kind, key, data_in, output ready);
endinterface

interface lfu_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic [lfu_pkg::DATA_W-1:0] data_out;

  modport source (output valid, hit, data_out, input ready);
  modport sink   (input valid, hit, data_out, output ready);
endinterface

// ----- design/lfu_cache_lru_tiebreak.sv -----
// Channel   Dir  Payload               Transfer
// in_ch     in   kind, key, data_in    valid && ready
// out_ch    out  hit, data_out         valid && ready
// cfg       in   cfg_wdata (capacity)  cfg_we
//
// A get, a put that hits, or a put with room is accepted, then looked up.
// A put that must evict also sweeps after lookup: the victim candidate walks the
// cell row one cell per cycle before the victim slot is refilled.
// Reset clears all valid bits and occupancy; capacity returns to 16.
// A stalled result holds in the output register; the next item is accepted and
// waits in lookup, or at the end of its sweep, until the output register frees.
module lfu_cache_lru_tiebreak (
  input  logic                       clk,
  input  logic                       rst_n,
  lfu_req_if.sink                    in_ch,
  lfu_rsp_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [lfu_pkg::CAP_W-1:0]  cfg_wdata
);

  localparam int N = lfu_pkg::ENTRIES;

  lfu_pkg::state_t               state_r, state_nxt;
  logic [lfu_pkg::CAP_W-1:0]     cap_r;
  logic [lfu_pkg::OCC_W-1:0]     occ_r, occ_nxt;
  logic [lfu_pkg::IDX_W-1:0]     sweep_cnt_r, sweep_cnt_nxt;
  logic                          item_kind_r;
  logic [lfu_pkg::KEY_W-1:0]     item_key_r;
  logic [lfu_pkg::DATA_W-1:0]    item_data_r;
  logic                          out_valid_r;
  logic                          out_hit_r, out_hit_nxt;
  logic [lfu_pkg::DATA_W-1:0]    out_data_r, out_data_nxt;
  logic                          out_load;
  logic                          out_free;
  logic                          in_rdy;

  lfu_pkg::cell_cmd_t            cmd;
  logic [N-1:0]                  sel_vec;
  lfu_pkg::cell_stat_t           stat [N];
  lfu_pkg::cand_t                cand [N+1];

  logic [N-1:0]                  hit_vec;
  logic [N-1:0]                  valid_vec;
  logic [N-1:0]                  free_vec;
  logic [N-1:0]                  free_oh;
  logic [N-1:0]                  vict_oh;
  logic [lfu_pkg::DATA_W-1:0]    hit_data;
  logic [lfu_pkg::IDX_W-1:0]     hit_rank;
  logic [lfu_pkg::LVL_W-1:0]     cap_lvl, cap_eff, occ_lvl;
  logic                          any_hit;
  logic                          full;
  logic                          cap_zero;
  lfu_pkg::cand_t                victim;

  assign cand[0] = '0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    lfu_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .sel      (sel_vec[g]),
      .idx      (lfu_pkg::IDX_W'(g)),
      .cand_in  (cand[g]),
      .cand_out (cand[g+1]),
      .stat     (stat[g])
    );
  end

  always_comb begin
    hit_data = '0;
    hit_rank = '0;
    for (int i = 0; i < N; i++) begin
      hit_vec[i]   = stat[i].hit;
      valid_vec[i] = stat[i].vld;
      hit_data     = hit_data | stat[i].data;
      hit_rank     = hit_rank | stat[i].rank;
    end
  end

  assign any_hit  = |hit_vec;
  assign free_vec = ~valid_vec;
  assign free_oh  = free_vec & (~free_vec + 1'b1);
  assign victim   = cand[N];
  assign vict_oh  = N'(1) << victim.idx;

  assign cap_lvl  = lfu_pkg::LVL_W'(cap_r);
  assign cap_eff  = (cap_lvl > lfu_pkg::LVL_W'(N)) ? lfu_pkg::LVL_W'(N) : cap_lvl;
  assign cap_zero = (cap_r == '0);
  assign occ_lvl  = lfu_pkg::LVL_W'(occ_r);
  assign full     = (occ_lvl >= cap_eff);
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    occ_nxt       = occ_r;
    sweep_cnt_nxt = sweep_cnt_r;
    in_rdy        = 1'b0;
    out_load      = 1'b0;
    out_hit_nxt   = 1'b0;
    out_data_nxt  = '0;
    sel_vec       = '0;
    cmd.op        = lfu_pkg::CELL_IDLE;
    cmd.wr_data   = 1'b0;
    cmd.rank      = hit_rank;
    cmd.key       = item_key_r;
    cmd.data      = item_data_r;
    case (state_r)
      lfu_pkg::ST_IDLE: begin
        in_rdy = 1'b1;
        if (in_ch.valid) begin
          state_nxt = lfu_pkg::ST_LOOKUP;
        end
      end
      lfu_pkg::ST_LOOKUP: begin
        if (item_kind_r == lfu_pkg::KIND_PUT && !cap_zero && !any_hit && full) begin
          state_nxt     = lfu_pkg::ST_SWEEP;
          sweep_cnt_nxt = '0;
        end else if (out_free) begin
          state_nxt = lfu_pkg::ST_IDLE;
          out_load  = 1'b1;
          if (item_kind_r == lfu_pkg::KIND_GET) begin
            out_hit_nxt  = any_hit;
            out_data_nxt = hit_data;
            if (any_hit) begin
              cmd.op  = lfu_pkg::CELL_BUMP;
              sel_vec = hit_vec;
            end
          end else if (!cap_zero) begin
            out_hit_nxt = any_hit;
            if (any_hit) begin
              cmd.op      = lfu_pkg::CELL_BUMP;
              cmd.wr_data = 1'b1;
              sel_vec     = hit_vec;
            end else begin
              cmd.op  = lfu_pkg::CELL_INSERT;
              sel_vec = free_oh;
              occ_nxt = occ_r + 1'b1;
            end
          end
        end
      end
      lfu_pkg::ST_SWEEP: begin
        if (sweep_cnt_r == lfu_pkg::IDX_W'(N - 1)) begin
          if (out_free) begin
            // evict and insert in one step: the victim slot takes the new key
            state_nxt = lfu_pkg::ST_IDLE;
            out_load  = 1'b1;
            cmd.op    = lfu_pkg::CELL_FILL;
            cmd.rank  = victim.rank;
            sel_vec   = vict_oh;
          end
        end else begin
          sweep_cnt_nxt = sweep_cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = lfu_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lfu_pkg::ST_IDLE;
      occ_r       <= '0;
      sweep_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lfu_pkg::CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_ch.valid) begin
      item_kind_r <= in_ch.kind;
      item_key_r  <= in_ch.key;
      item_data_r <= in_ch.data_in;
    end
    if (out_load) begin
      out_hit_r  <= out_hit_nxt;
      out_data_r <= out_data_nxt;
    end
  end

  assign in_ch.ready     = in_rdy;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.hit      = out_hit_r;
  assign out_ch.data_out = out_data_r;

  a_key_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec))
    else $error("key present in more than one slot");

  a_occ_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(occ_r))
    else $error("occupancy differs from number of valid slots");

  a_victim_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lfu_pkg::ST_SWEEP && sweep_cnt_r == lfu_pkg::IDX_W'(N - 1))
      |-> victim.vld)
    else $error("sweep ended without a victim");

  a_insert_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == lfu_pkg::CELL_INSERT) |-> ((sel_vec & valid_vec) == '0 && $onehot(sel_vec)))
    else $error("insert into an occupied or missing slot");

endmodule

// ----- design/lfu_cell.sv -----
module lfu_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lfu_pkg::cell_cmd_t         cmd,
  input  logic                       sel,
  input  logic [lfu_pkg::IDX_W-1:0]  idx,
  input  lfu_pkg::cand_t             cand_in,
  output lfu_pkg::cand_t             cand_out,
  output lfu_pkg::cell_stat_t        stat
);

  logic                           valid_r;
  logic [lfu_pkg::KEY_W-1:0]      key_r, key_nxt;
  logic [lfu_pkg::DATA_W-1:0]     data_r, data_nxt;
  logic [lfu_pkg::COUNT_BITS-1:0] count_r, count_nxt;
  logic [lfu_pkg::IDX_W-1:0]      rank_r, rank_nxt;
  lfu_pkg::cand_t                 cand_r, cand_nxt;
  logic                           ages;
  logic                           mine_better;
  logic                           key_hit;

  // entries more recent than the touched one age by one
  assign ages = valid_r && (rank_r < cmd.rank);

  always_comb begin
    key_nxt   = key_r;
    data_nxt  = data_r;
    count_nxt = count_r;
    rank_nxt  = rank_r;
    case (cmd.op)
      lfu_pkg::CELL_BUMP: begin
        if (sel) begin
          if (count_r != lfu_pkg::COUNT_MAX) begin
            count_nxt = count_r + lfu_pkg::COUNT_ONE;
          end
          rank_nxt = '0;
          if (cmd.wr_data) begin
            data_nxt = cmd.data;
          end
        end else if (ages) begin
          rank_nxt = rank_r + 1'b1;
        end
      end
      lfu_pkg::CELL_FILL: begin
        if (sel) begin
          key_nxt   = cmd.key;
          data_nxt  = cmd.data;
          count_nxt = lfu_pkg::COUNT_ONE;
          rank_nxt  = '0;
        end else if (ages) begin
          rank_nxt = rank_r + 1'b1;
        end
      end
      lfu_pkg::CELL_INSERT: begin
        if (sel) begin
          key_nxt   = cmd.key;
          data_nxt  = cmd.data;
          count_nxt = lfu_pkg::COUNT_ONE;
          rank_nxt  = '0;
        end else if (valid_r) begin
          rank_nxt = rank_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (sel && cmd.op == lfu_pkg::CELL_INSERT) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    data_r  <= data_nxt;
    count_r <= count_nxt;
    rank_r  <= rank_nxt;
  end

  // victim search: keep the lower count, on equal count the older rank
  assign mine_better = valid_r &&
                       (!cand_in.vld || (count_r < cand_in.cnt) ||
                        (count_r == cand_in.cnt && rank_r > cand_in.rank));

  always_comb begin
    cand_nxt = cand_in;
    if (mine_better) begin
      cand_nxt.vld  = 1'b1;
      cand_nxt.cnt  = count_r;
      cand_nxt.rank = rank_r;
      cand_nxt.idx  = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r <= '0;
    end else begin
      cand_r <= cand_nxt;
    end
  end

  assign cand_out = cand_r;

  assign key_hit   = valid_r && (key_r == cmd.key);
  assign stat.vld  = valid_r;
  assign stat.hit  = key_hit;
  assign stat.rank = key_hit ? rank_r : '0;
  assign stat.data = key_hit ? data_r : '0;

endmodule

// ----- sim/lfu_cache_checker.sv -----
`timescale 1ns / 100ps

module lfu_cache_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  lfu_req_if                        req,
  lfu_rsp_if                        rsp,
  input  logic                      cfg_we,
  input  logic [lfu_pkg::CAP_W-1:0] cfg_wdata,
  output int                        fail_count,
  output int                        outstanding
);

  typedef struct packed {
    logic                       hit;
    logic [lfu_pkg::DATA_W-1:0] data;
  } lookup_t;

  logic                           slot_vld  [lfu_pkg::ENTRIES];
  logic [lfu_pkg::KEY_W-1:0]      slot_key  [lfu_pkg::ENTRIES];
  logic [lfu_pkg::DATA_W-1:0]     slot_data [lfu_pkg::ENTRIES];
  logic [lfu_pkg::COUNT_BITS-1:0] slot_cnt  [lfu_pkg::ENTRIES];
  logic [lfu_pkg::IDX_W-1:0]      slot_rank [lfu_pkg::ENTRIES];
  int                             slot_occ;
  logic [lfu_pkg::CAP_W-1:0]      capacity;
  lookup_t                        expected_lookups[$];

  task automatic clear_store();
    capacity = lfu_pkg::CAP_RESET;
    slot_occ = 0;
    for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
      slot_vld[i]  = 1'b0;
      slot_key[i]  = '0;
      slot_data[i] = '0;
      slot_cnt[i]  = '0;
      slot_rank[i] = '0;
    end
    expected_lookups.delete();
  endtask

  // Move slot s to the front; entries that were ahead of it age by one.
  task automatic promote(input int s);
    logic [lfu_pkg::IDX_W-1:0] r;
    r = slot_rank[s];
    for (int i = 0; i < lfu_pkg::ENTRIES; i++)
      if (slot_vld[i] && i != s && slot_rank[i] < r) slot_rank[i]++;
    slot_rank[s] = '0;
  endtask

  task automatic touch_slot(input int s);
    if (slot_cnt[s] != lfu_pkg::COUNT_MAX) slot_cnt[s]++;
    promote(s);
  endtask

  task automatic predict_lookup(input logic kind, input logic [lfu_pkg::KEY_W-1:0] key,
                                input logic [lfu_pkg::DATA_W-1:0] din,
                                output lookup_t res);
    int s;
    int victim;
    int free_slot;
    int eff_cap;
    s         = -1;
    victim    = -1;
    free_slot = -1;
    for (int i = 0; i < lfu_pkg::ENTRIES; i++)
      if (s < 0 && slot_vld[i] && slot_key[i] == key) s = i;
    res.hit  = (s >= 0);
    res.data = '0;
    eff_cap  = (capacity > lfu_pkg::ENTRIES) ? lfu_pkg::ENTRIES : int'(capacity);

    if (kind == lfu_pkg::KIND_GET) begin
      if (s >= 0) begin
        res.data = slot_data[s];
        touch_slot(s);
      end
    end else if (eff_cap == 0) begin
      res.hit = 1'b0;
    end else if (s >= 0) begin
      slot_data[s] = din;
      touch_slot(s);
    end else begin
      if (slot_occ >= eff_cap) begin
        // lowest count wins, oldest rank breaks the tie
        for (int i = 0; i < lfu_pkg::ENTRIES; i++)
          if (slot_vld[i] && (victim < 0 || slot_cnt[i] < slot_cnt[victim] ||
              (slot_cnt[i] == slot_cnt[victim] && slot_rank[i] > slot_rank[victim])))
            victim = i;
        if (victim >= 0) begin
          for (int i = 0; i < lfu_pkg::ENTRIES; i++)
            if (slot_vld[i] && slot_rank[i] > slot_rank[victim]) slot_rank[i]--;
          slot_vld[victim] = 1'b0;
          if (slot_occ > 0) slot_occ--;
        end
      end
      for (int i = 0; i < lfu_pkg::ENTRIES; i++)
        if (free_slot < 0 && !slot_vld[i]) free_slot = i;
      if (free_slot >= 0) begin
        for (int i = 0; i < lfu_pkg::ENTRIES; i++)
          if (slot_vld[i]) slot_rank[i]++;
        slot_vld[free_slot]  = 1'b1;
        slot_key[free_slot]  = key;
        slot_data[free_slot] = din;
        slot_cnt[free_slot]  = lfu_pkg::COUNT_ONE;
        slot_rank[free_slot] = '0;
        slot_occ++;
      end
    end
  endtask

  always @(posedge clk) begin
    lookup_t want;
    lookup_t predicted;
    int      errs;
    errs = 0;
    if (!rst_n) begin
      clear_store();
      fail_count  <= 0;
      outstanding <= 0;
    end else begin
      if (cfg_we) capacity = cfg_wdata;

      // check the response first: it can never belong to a same-edge request
      if (rsp.valid && rsp.ready) begin
        if (expected_lookups.size() == 0) begin
          $error("response transfer with nothing outstanding: hit=%0b data_out=%08h",
                 rsp.hit, rsp.data_out);
          errs++;
        end else begin
          want = expected_lookups.pop_front();
          if (rsp.hit !== want.hit) begin
            $error("hit: expected %0b, actual %0b", want.hit, rsp.hit);
            errs++;
          end
          if (rsp.data_out !== want.data) begin
            $error("data_out: expected %08h, actual %08h", want.data, rsp.data_out);
            errs++;
          end
        end
      end

      if (req.valid && req.ready) begin
        predict_lookup(req.kind, req.key, req.data_in, predicted);
        expected_lookups.push_back(predicted);
      end

      fail_count  <= fail_count + errs;
      outstanding <= expected_lookups.size();
    end
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 8;
  localparam int SETTLE_CYCLES  = 2 * (2 + lfu_pkg::ENTRIES);
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int POOL_MAX       = 24;
  localparam int HAMMER_GETS    = 12;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_we;
  logic [lfu_pkg::CAP_W-1:0] cfg_wdata;
  int                        fail_count;
  int                        outstanding;
  logic                      hold_req;
  logic                      rx_free;
  logic [lfu_pkg::KEY_W-1:0] key_pool [POOL_MAX];

  lfu_req_if in_ch();
  lfu_rsp_if out_ch();

  lfu_cache_lru_tiebreak i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  lfu_cache_checker i_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (in_ch),
    .rsp         (out_ch),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Response side: long hold-off on request, otherwise a stall pattern that changes mode.
  initial begin
    int         rx_cyc;
    int         rx_mode;
    logic [7:0] rx_pattern;
    logic       rdy;
    logic       hold_done;
    rx_cyc       = 0;
    rx_mode      = 0;
    rx_pattern   = 8'hFF;
    hold_done    = 1'b0;
    out_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
        out_ch.ready <= 1'b1;
      end else begin
        if (rx_cyc % 48 == 0) begin
          rx_mode    = $urandom_range(0, 3);
          rx_pattern = 8'($urandom) | 8'h01;
        end
        case (rx_mode)
          0:       rdy = 1'b1;
          1:       rdy = ($urandom_range(0, 3) != 0);
          2:       rdy = ($urandom_range(0, 9) < 3);
          default: rdy = rx_pattern[3'(rx_cyc % 8)];
        endcase
        out_ch.ready <= rdy | rx_free;
        rx_cyc++;
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_item(input logic kind, input logic [lfu_pkg::KEY_W-1:0] key,
                           input logic [lfu_pkg::DATA_W-1:0] din);
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.kind    <= kind;
    in_ch.key     <= key;
    in_ch.data_in <= din;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (n - 1) @(posedge clk);
    end
  endtask

  // Hold the request side until every lookup has come back.
  task automatic drain();
    idle_gap(1);
    wait (outstanding == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [lfu_pkg::CAP_W-1:0] cap);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic refill_pool();
    for (int i = 0; i < POOL_MAX; i++) key_pool[i] = $urandom;
  endtask

  task automatic run_random(input int n, input int pool_sz, input bit press,
                            input bit pause_mid);
    int                        burst_left;
    int                        pick;
    int                        hot;
    logic                      kind;
    logic [lfu_pkg::KEY_W-1:0] key;
    burst_left = 0;
    hot        = (pool_sz < 3) ? pool_sz : 3;
    if (press) hold_req = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2) begin
        idle_gap(1);
        wait (outstanding == 0);
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        // keep offering back to back while the response side is held off
        if (!(press && i < 48))
          idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
      end
      burst_left--;
      pick = $urandom_range(0, 99);
      if (pick < 8)       key = $urandom;
      else if (pick < 40) key = key_pool[$urandom_range(0, hot - 1)];
      else                key = key_pool[$urandom_range(0, pool_sz - 1)];
      kind = ($urandom_range(0, 99) < 45) ? lfu_pkg::KIND_PUT : lfu_pkg::KIND_GET;
      send_item(kind, key, $urandom);
    end
  endtask

  initial begin
    logic [lfu_pkg::KEY_W-1:0] sat_key;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    hold_req      = 1'b0;
    rx_free       = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.kind    = lfu_pkg::KIND_GET;
    in_ch.key     = '0;
    in_ch.data_in = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // field extremes, overwrite, fill to 16, then one eviction
    send_item(lfu_pkg::KIND_GET, '0, '1);
    send_item(lfu_pkg::KIND_PUT, '0, '0);
    send_item(lfu_pkg::KIND_PUT, '1, '1);
    send_item(lfu_pkg::KIND_GET, '0, '0);
    send_item(lfu_pkg::KIND_GET, '1, '0);
    send_item(lfu_pkg::KIND_PUT, '0, 32'hA5A5_A5A5);
    send_item(lfu_pkg::KIND_GET, '0, '0);
    send_item(lfu_pkg::KIND_GET, 32'h1234_5678, '0);
    for (int k = 1; k <= 14; k++)
      send_item(lfu_pkg::KIND_PUT, lfu_pkg::KEY_W'(k), $urandom);
    send_item(lfu_pkg::KIND_PUT, 32'h0000_0100, 32'h5A5A_5A5A);
    send_item(lfu_pkg::KIND_GET, 32'h0000_0001, '0);
    send_item(lfu_pkg::KIND_GET, 32'h0000_0100, '0);

    // capacity dropped below occupancy: each new key swaps out exactly one entry
    refill_pool();
    set_capacity(lfu_pkg::CAP_W'(3));
    send_item(lfu_pkg::KIND_PUT, key_pool[0], $urandom);
    send_item(lfu_pkg::KIND_PUT, key_pool[1], $urandom);
    run_random(80, 6, 1'b0, 1'b0);

    // puts do nothing, gets still see what is stored
    set_capacity('0);
    run_random(60, 6, 1'b0, 1'b0);

    set_capacity('1);
    refill_pool();
    run_random(120, 22, 1'b1, 1'b0);

    set_capacity(lfu_pkg::CAP_W'(1));
    refill_pool();
    run_random(60, 3, 1'b0, 1'b0);

    set_capacity(lfu_pkg::CAP_W'(17));
    refill_pool();
    run_random(80, 20, 1'b0, 1'b0);

    set_capacity(lfu_pkg::CAP_W'(7));
    refill_pool();
    run_random(100, 11, 1'b0, 1'b1);

    // hammer one key with gets back to back, then overwrite it and read it back
    set_capacity(lfu_pkg::CAP_W'(16));
    refill_pool();
    sat_key = key_pool[0];
    rx_free = 1'b1;
    send_item(lfu_pkg::KIND_PUT, sat_key, $urandom);
    for (int i = 0; i < HAMMER_GETS; i++) send_item(lfu_pkg::KIND_GET, sat_key, '0);
    send_item(lfu_pkg::KIND_PUT, sat_key, $urandom);
    send_item(lfu_pkg::KIND_GET, sat_key, '0);
    rx_free = 1'b0;
    run_random(150, 20, 1'b0, 1'b0);

    drain();
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
